@@ rtl/core/bspq_pkg.sv @@
// ----------------------------------------------------------------------------
// bspq_pkg
// Shared types and constants for the bounded stable priority queue: default
// sizes, command and status codes, and the controller-to-datapath command.
// ----------------------------------------------------------------------------
package bspq_pkg;

	// default sizing
	localparam int DEF_CAPACITY      = 8;
	localparam int DEF_PRIORITY_BITS = 4;

	// payload widths fixed by the interface
	localparam int VALUE_W  = 8;
	localparam int PRIO_W   = 4;
	localparam int STATUS_W = 2;
	localparam int FILL_W   = 4;

	// answer on a dequeue from an empty queue (ascii space)
	localparam logic [VALUE_W-1:0] EMPTY_ANSWER = 8'd32;

	// operation codes on the mode port
	localparam logic MODE_ENQUEUE = 1'b0;
	localparam logic MODE_DEQUEUE = 1'b1;

	// result status codes
	localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

	// commands from the controller to the datapath
	typedef struct packed {
		logic load;  // capture the request on the input ports
		logic exec;  // apply the captured request to the slots
	} bspq_cmd_t;

endpackage

@@ rtl/core/bspq_ctrl.sv @@
// ----------------------------------------------------------------------------
// bspq_ctrl
// Two-state controller: accepts a request while idle, then holds its work
// state while the datapath applies it to the sorted slot array.
// ----------------------------------------------------------------------------
module bspq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	output bspq_pkg::bspq_cmd_t cmd
);
	import bspq_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_WORK = 2'b10
	} state_t;

	state_t state_q;
	state_t state_nxt;

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) state_nxt = ST_WORK;
			end
			ST_WORK: begin
				state_nxt = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_nxt;
	end

	// handshake and datapath commands
	assign busy     = (state_q != ST_IDLE);
	assign cmd.load = start && (state_q == ST_IDLE);
	assign cmd.exec = (state_q == ST_WORK);

endmodule

@@ rtl/core/bspq_datapath.sv @@
// ----------------------------------------------------------------------------
// bspq_datapath
// Sorted slot array with the head in slot 0. Every slot compares its own
// priority with the request in parallel; an insert shifts the tail up by one,
// a removal shifts everything down by one. Also holds the result registers.
// ----------------------------------------------------------------------------
module bspq_datapath #(
	parameter int CAPACITY      = bspq_pkg::DEF_CAPACITY,
	parameter int PRIORITY_BITS = bspq_pkg::DEF_PRIORITY_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  bspq_pkg::bspq_cmd_t             cmd,
	input  logic                            mode,
	input  logic [bspq_pkg::VALUE_W-1:0]    entry_value,
	input  logic [bspq_pkg::PRIO_W-1:0]     priority_level,
	output logic                            done,
	output logic [bspq_pkg::VALUE_W-1:0]    served_value,
	output logic [bspq_pkg::STATUS_W-1:0]   status,
	output logic [bspq_pkg::FILL_W-1:0]     fill_level
);
	import bspq_pkg::*;

	localparam int OCC_W = $clog2(CAPACITY + 1);

	// captured request
	logic                     mode_q;
	logic [VALUE_W-1:0]       value_q;
	logic [PRIORITY_BITS-1:0] prio_q;

	// slot array and fill count
	logic [VALUE_W-1:0]       slot_val_q [CAPACITY];
	logic [PRIORITY_BITS-1:0] slot_pri_q [CAPACITY];
	logic [OCC_W-1:0]         occ_q;

	// result registers
	logic                done_q;
	logic [VALUE_W-1:0]  served_q;
	logic [STATUS_W-1:0] status_q;
	logic [FILL_W-1:0]   fill_q;

	// per-slot compare results and next contents
	logic [CAPACITY-1:0]      occupied;
	logic [CAPACITY-1:0]      stay;
	logic [VALUE_W-1:0]       ins_val [CAPACITY];
	logic [PRIORITY_BITS-1:0] ins_pri [CAPACITY];
	logic [VALUE_W-1:0]       del_val [CAPACITY];
	logic [PRIORITY_BITS-1:0] del_pri [CAPACITY];

	logic             is_full;
	logic             queue_drained;
	logic             do_insert;
	logic             do_remove;
	logic [OCC_W-1:0] occ_nxt;

	// request capture; priority keeps only the bits the slots hold
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q  <= mode;
			value_q <= entry_value;
			prio_q  <= PRIORITY_BITS'(priority_level);
		end
	end

	assign is_full       = (occ_q == OCC_W'(CAPACITY));
	assign queue_drained = (occ_q == '0);
	assign do_insert     = cmd.exec && (mode_q == MODE_ENQUEUE) && !is_full;
	assign do_remove     = cmd.exec && (mode_q == MODE_DEQUEUE) && !queue_drained;

	// one cell per slot: an entry stays put when it is held and ranks at or
	// before the new one; the first slot past that prefix takes the new entry
	for (genvar g = 0; g < CAPACITY; g++) begin : g_slot
		assign occupied[g] = (occ_q > OCC_W'(g));
		assign stay[g]     = occupied[g] && (slot_pri_q[g] <= prio_q);

		if (g == 0) begin : g_head
			assign ins_val[g] = stay[g] ? slot_val_q[g] : value_q;
			assign ins_pri[g] = stay[g] ? slot_pri_q[g] : prio_q;
		end else begin : g_body
			assign ins_val[g] = stay[g]     ? slot_val_q[g]   :
			                    stay[g-1]   ? value_q         : slot_val_q[g-1];
			assign ins_pri[g] = stay[g]     ? slot_pri_q[g]   :
			                    stay[g-1]   ? prio_q          : slot_pri_q[g-1];
		end

		if (g == CAPACITY - 1) begin : g_last
			assign del_val[g] = slot_val_q[g];
			assign del_pri[g] = slot_pri_q[g];
		end else begin : g_inner
			assign del_val[g] = slot_val_q[g+1];
			assign del_pri[g] = slot_pri_q[g+1];
		end

		// slot storage
		always_ff @(posedge clk) begin
			if (do_insert) begin
				slot_val_q[g] <= ins_val[g];
				slot_pri_q[g] <= ins_pri[g];
			end else if (do_remove) begin
				slot_val_q[g] <= del_val[g];
				slot_pri_q[g] <= del_pri[g];
			end
		end
	end

	// fill count after this step
	always_comb begin
		occ_nxt = occ_q;
		if (do_insert)      occ_nxt = occ_q + OCC_W'(1);
		else if (do_remove) occ_nxt = occ_q - OCC_W'(1);
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q  <= '0;
			done_q <= 1'b0;
		end else begin
			occ_q  <= occ_nxt;
			done_q <= cmd.exec;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			fill_q <= FILL_W'(occ_nxt);
			if (mode_q == MODE_ENQUEUE) begin
				served_q <= '0;
				status_q <= is_full ? STATUS_FULL : STATUS_DONE;
			end else if (queue_drained) begin
				served_q <= EMPTY_ANSWER;
				status_q <= STATUS_EMPTY;
			end else begin
				served_q <= slot_val_q[0];
				status_q <= STATUS_DONE;
			end
		end
	end

	assign done         = done_q;
	assign served_value = served_q;
	assign status       = status_q;
	assign fill_level   = fill_q;

endmodule

@@ rtl/core/bounded_stable_priority_queue.sv @@
// ----------------------------------------------------------------------------
// bounded_stable_priority_queue
// Bounded priority queue of bytes, lowest priority number first, equal
// priorities in arrival order.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. busy is high for
// the one cycle in which the slot array is updated, and the result follows
// on the cycle after with done high for exactly one cycle; the receiver
// cannot stall it. A new request may be offered in the same cycle that a
// result is shown, but none is taken while one is being applied. The
// controller has a single work state, in which every slot compares and
// shifts in parallel. An enqueue into a full queue reports status full and
// changes nothing; a dequeue from an empty queue returns a space (32) with
// status empty. fill_level carries the low four bits of the count held
// after the step.
// ----------------------------------------------------------------------------
module bounded_stable_priority_queue #(
	parameter int CAPACITY      = bspq_pkg::DEF_CAPACITY,
	parameter int PRIORITY_BITS = bspq_pkg::DEF_PRIORITY_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          mode,
	input  logic [bspq_pkg::VALUE_W-1:0]  entry_value,
	input  logic [bspq_pkg::PRIO_W-1:0]   priority_level,
	output logic                          done,
	output logic [bspq_pkg::VALUE_W-1:0]  served_value,
	output logic [bspq_pkg::STATUS_W-1:0] status,
	output logic [bspq_pkg::FILL_W-1:0]   fill_level
);
	import bspq_pkg::*;

	bspq_cmd_t cmd;

	// sequencing
	bspq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd)
	);

	// slot array and results
	bspq_datapath #(
		.CAPACITY      (CAPACITY),
		.PRIORITY_BITS (PRIORITY_BITS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.mode           (mode),
		.entry_value    (entry_value),
		.priority_level (priority_level),
		.done           (done),
		.served_value   (served_value),
		.status         (status),
		.fill_level     (fill_level)
	);

endmodule

@@ tb/bspq_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bspq_checker
// Watches the request and result channels of the bounded stable priority
// queue. Keeps its own sorted copy of the held entries, works out the
// expected result of each accepted request, and compares each result
// field by field with the oldest outstanding expectation.
// ----------------------------------------------------------------------------
module bspq_checker #(
	parameter int CAPACITY      = bspq_pkg::DEF_CAPACITY,
	parameter int PRIORITY_BITS = bspq_pkg::DEF_PRIORITY_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          busy,
	input  logic                          mode,
	input  logic [bspq_pkg::VALUE_W-1:0]  entry_value,
	input  logic [bspq_pkg::PRIO_W-1:0]   priority_level,
	input  logic                          done,
	input  logic [bspq_pkg::VALUE_W-1:0]  served_value,
	input  logic [bspq_pkg::STATUS_W-1:0] status,
	input  logic [bspq_pkg::FILL_W-1:0]   fill_level,
	output int                            fail_count,
	output int                            pending_count
);
	import bspq_pkg::*;

	typedef struct {
		logic [VALUE_W-1:0]  value;
		logic [STATUS_W-1:0] code;
		logic [FILL_W-1:0]   fill;
	} queue_answer_t;

	// shadow of the slot array, slot 0 is the head
	logic [VALUE_W-1:0] held_values [CAPACITY];
	logic [PRIO_W-1:0]  held_prios  [CAPACITY];
	int                 held_count;

	queue_answer_t due_answers[$];

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
		fail_count++;
	endtask

	// apply one request to the shadow queue and return its answer
	task automatic serve_request(input logic m, input logic [VALUE_W-1:0] v,
			input logic [PRIO_W-1:0] p, output queue_answer_t ans);
		logic [PRIO_W-1:0] eff_prio;
		int pos;
		eff_prio = p & PRIO_W'((1 << PRIORITY_BITS) - 1);
		ans.value = '0;
		ans.code = STATUS_DONE;
		if (m == MODE_ENQUEUE) begin
			if (held_count >= CAPACITY) begin
				ans.code = STATUS_FULL;
			end else begin
				// stable insert: after every entry of equal or better priority
				pos = 0;
				while (pos < held_count && held_prios[pos] <= eff_prio)
					pos++;
				for (int i = held_count; i > pos; i--) begin
					held_values[i] = held_values[i-1];
					held_prios[i] = held_prios[i-1];
				end
				held_values[pos] = v;
				held_prios[pos] = eff_prio;
				held_count++;
			end
		end else if (held_count == 0) begin
			ans.value = EMPTY_ANSWER;
			ans.code = STATUS_EMPTY;
		end else begin
			ans.value = held_values[0];
			for (int i = 1; i < held_count; i++) begin
				held_values[i-1] = held_values[i];
				held_prios[i-1] = held_prios[i];
			end
			held_count--;
		end
		ans.fill = FILL_W'(held_count);
	endtask

	// results are checked before the request of the same edge is queued
	always @(posedge clk or negedge arst_n) begin
		queue_answer_t want, fresh;
		if (!arst_n) begin
			held_count = 0;
			due_answers.delete();
			fail_count = 0;
			pending_count = 0;
		end else begin
			if (done) begin
				if (due_answers.size() == 0) begin
					$display("%0t ns: result transfer with nothing outstanding", $time);
					fail_count++;
				end else begin
					want = due_answers.pop_front();
					if (served_value !== want.value)
						report_mismatch("served_value", int'(served_value),
							int'(want.value));
					if (status !== want.code)
						report_mismatch("status", int'(status), int'(want.code));
					if (fill_level !== want.fill)
						report_mismatch("fill_level", int'(fill_level), int'(want.fill));
				end
			end
			if (start && !busy) begin
				serve_request(mode, entry_value, priority_level, fresh);
				due_answers.push_back(fresh);
			end
			pending_count = due_answers.size();
		end
	end

endmodule

@@ tb/tb_bounded_stable_priority_queue.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bounded_stable_priority_queue
// Drives enqueue and dequeue requests into the priority queue: a directed
// pass through empty, full, tie and extreme cases, then random traffic that
// swings the fill level between empty and full. The checker beside the
// block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_bounded_stable_priority_queue;
	import bspq_pkg::*;

	localparam int RANDOM_ITEMS = 600;
	localparam int CYCLE_LIMIT  = 50000;
	localparam int DRAIN_CYCLES = 5;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic                mode;
	logic [VALUE_W-1:0]  entry_value;
	logic [PRIO_W-1:0]   priority_level;
	logic                done;
	logic [VALUE_W-1:0]  served_value;
	logic [STATUS_W-1:0] status;
	logic [FILL_W-1:0]   fill_level;
	int                  fail_count;
	int                  pending_count;
	int                  cycle_count = 0;

	bounded_stable_priority_queue DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.mode(mode),
		.entry_value(entry_value),
		.priority_level(priority_level),
		.done(done),
		.served_value(served_value),
		.status(status),
		.fill_level(fill_level)
	);

	bspq_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.mode(mode),
		.entry_value(entry_value),
		.priority_level(priority_level),
		.done(done),
		.served_value(served_value),
		.status(status),
		.fill_level(fill_level),
		.fail_count(fail_count),
		.pending_count(pending_count)
	);

	// 2 ns clock
	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// run guard
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// one request transfer; called and returns at a falling edge
	task automatic push_request(input logic m, input logic [VALUE_W-1:0] v,
			input logic [PRIO_W-1:0] p);
		int gap;
		gap = $urandom_range(0, 3);
		if (gap > 0) begin
			start <= 1'b0;
			mode <= 1'($urandom_range(0, 1));
			entry_value <= VALUE_W'($urandom);
			priority_level <= PRIO_W'($urandom);
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		mode <= m;
		entry_value <= v;
		priority_level <= p;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	task automatic enqueue(input logic [VALUE_W-1:0] v, input logic [PRIO_W-1:0] p);
		push_request(MODE_ENQUEUE, v, p);
	endtask

	// dequeue carries random don't-care payload
	task automatic dequeue();
		push_request(MODE_DEQUEUE, VALUE_W'($urandom), PRIO_W'($urandom));
	endtask

	initial begin
		int sent;
		int enq_pct;
		bit narrow;
		arst_n = 1'b0;
		start = 1'b0;
		mode = MODE_ENQUEUE;
		entry_value = '0;
		priority_level = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: empty dequeue, extremes, ties, full rejects, drain
		dequeue();
		enqueue(8'hFF, 4'd15);
		enqueue(8'h00, 4'd0);
		enqueue(8'hAA, 4'd5);
		enqueue(8'h55, 4'd5);
		enqueue(8'h11, 4'd5);
		enqueue(8'h22, 4'd15);
		enqueue(8'h33, 4'd0);
		enqueue(8'h44, 4'd10);
		enqueue(8'h99, 4'd0);
		enqueue(8'h77, 4'd15);
		repeat (8) dequeue();
		dequeue();
		enqueue(8'h5A, 4'd7);
		dequeue();

		// random: stretches biased toward filling, draining or balanced
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			case ($urandom_range(0, 2))
				0: enq_pct = 25;
				1: enq_pct = 50;
				default: enq_pct = 80;
			endcase
			narrow = $urandom_range(0, 1);
			repeat (30) begin
				if ($urandom_range(1, 100) <= enq_pct)
					enqueue(VALUE_W'($urandom),
						narrow ? PRIO_W'($urandom_range(0, 2)) : PRIO_W'($urandom));
				else
					dequeue();
				sent++;
			end
		end
		start <= 1'b0;

		// drain outstanding results
		wait (pending_count == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
